[rtl/name_to_index_hash_map_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the name-to-index hash map unit
// ----------------------------------------------------------------------------
`ifndef NAME_TO_INDEX_HASH_MAP_UNIT_MACROS_SVH
`define NAME_TO_INDEX_HASH_MAP_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define NIHM_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property violated");

// Check that a condition never holds on a rising clock edge outside reset
`define NIHM_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

[rtl/nihm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nihm_pkg
// Shared widths, constants and the name packing function of the
// name-to-index hash map unit.
// ----------------------------------------------------------------------------
package nihm_pkg;

    // Letters per name and width of one letter code
    localparam int NAME_LETTERS = 4;
    localparam int LETTER_W     = 5;

    // Width of the name index result port
    localparam int NAME_INDEX_W = 10;

    // 27^4 - 1 fits in 20 bits
    localparam int KEY_W = 20;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [NAME_LETTERS-1:0][LETTER_W-1:0] letters_t;

    localparam key_t        RADIX       = key_t'(27);
    localparam logic [31:0] HASH_GOLDEN = 32'd2654435769;

    // Pack letters into a base-27 key; positions after the end mark are zero
    function automatic key_t pack_key(input letters_t letters);
        key_t key;
        logic ended;
        key   = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_LETTERS; i++) begin
            if (letters[i] == '0) begin
                ended = 1'b1;
            end
            if (ended) begin
                key = key_t'(key * RADIX);
            end
            else begin
                key = key_t'(key * RADIX) + key_t'(letters[i]);
            end
        end
        return key;
    endfunction

endpackage

`default_nettype wire

[rtl/name_to_index_hash_map_unit.sv]
// ----------------------------------------------------------------------------
// name_to_index_hash_map_unit
// Maps names of up to four letters to sequential indexes through a chained,
// Fibonacci-hashed table held in synchronous memories.
//
// Input channel (in_valid/in_ready) carries letter0..letter3, codes 1..26,
// a zero code ends the name. Output channel (out_valid/out_ready) returns
// name_index, is_new and table_full, one result per request.
// One request is worked on at a time. From acceptance the unit passes
// through the hash, bucket and bucket-check states, one chain-node check
// per node visited, a write state on insert and a result state, which
// waits while an earlier result is still held, before in_ready returns.
// out_valid rises in the cycle after the result state hands off.
// A finished result sits in the output register, so a new request is taken
// while the receiver stalls; a second result waits until the first is taken.
// After reset the bucket memory is cleared, one bucket per cycle, with
// in_ready low; index count restarts at zero.
// When MAX_NAMES names are stored, new names return index 0 with table_full.
// ----------------------------------------------------------------------------
`default_nettype none

module name_to_index_hash_map_unit
    import nihm_pkg::*;
#(
    parameter int BUCKETS   = 32,
    parameter int MAX_NAMES = 1024
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire logic [LETTER_W-1:0]     letter0,
    input  wire logic [LETTER_W-1:0]     letter1,
    input  wire logic [LETTER_W-1:0]     letter2,
    input  wire logic [LETTER_W-1:0]     letter3,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      logic [NAME_INDEX_W-1:0] name_index,
    output      logic                    is_new,
    output      logic                    table_full
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int IDX_W = $clog2(MAX_NAMES);
    localparam int CNT_W = $clog2(MAX_NAMES + 1);

    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
    } bkt_entry_t;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_BKT   = 8'b0000_1000,
        S_BCHK  = 8'b0001_0000,
        S_NCHK  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    // Control registers
    state_t            state_reg, state_next;
    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    // Working payload registers
    key_t              key_reg, key_next;
    logic [31:0]       hash_reg, hash_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              res_new_reg, res_new_next;
    logic              res_full_reg, res_full_next;
    logic [NAME_INDEX_W-1:0] out_index_reg, out_index_next;
    logic              out_new_reg, out_new_next;
    logic              out_full_reg, out_full_next;

    // Memories and their ports
    bkt_entry_t        bkt_mem [BUCKETS];
    bkt_entry_t        bkt_rdata_reg;
    logic              bkt_we;
    logic [BKT_W-1:0]  bkt_waddr;
    bkt_entry_t        bkt_wdata;

    key_t              key_mem [MAX_NAMES];
    key_t              key_rdata_reg;
    logic              key_we;

    logic [IDX_W-1:0]  link_mem [MAX_NAMES];
    logic [IDX_W-1:0]  link_rdata_reg;
    logic              link_we;

    // Arithmetic and helpers
    logic [31:0]       hash_prod;
    logic [63:0]       bucket_prod;
    logic [IDX_W-1:0]  new_idx;
    logic [IDX_W+NAME_INDEX_W-1:0] idx_ext;
    logic              take_miss;

    assign hash_prod   = 32'(key_reg) * HASH_GOLDEN;
    assign bucket_prod = 64'(hash_reg) * 64'(BUCKETS);
    assign new_idx     = count_reg[IDX_W-1:0];
    assign idx_ext     = {{NAME_INDEX_W{1'b0}}, res_idx_reg};

    // Bucket memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_rdata_reg <= bkt_mem[bucket_next];
    end

    // Node key memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[new_idx] <= key_reg;
        end
        key_rdata_reg <= key_mem[node_next];
    end

    // Node link memory: the tail node is patched to point at the new node
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[bkt_rdata_reg.last] <= new_idx;
        end
        link_rdata_reg <= link_mem[node_next];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        hash_reg      <= hash_next;
        bucket_reg    <= bucket_next;
        node_reg      <= node_next;
        res_idx_reg   <= res_idx_next;
        res_new_reg   <= res_new_next;
        res_full_reg  <= res_full_next;
        out_index_reg <= out_index_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
    end

    // Sequencer: bucket clear, hash, bucket read, chain walk, insert, emit
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        bucket_next    = bucket_reg;
        node_next      = node_reg;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        out_index_next = out_index_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        bkt_we         = 1'b0;
        bkt_waddr      = bucket_reg;
        bkt_wdata      = '0;
        key_we         = 1'b0;
        link_we        = 1'b0;
        take_miss      = 1'b0;

        // Drop the held result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                bkt_wdata = '0;
                if (clr_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = pack_key({letter3, letter2, letter1, letter0});
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                hash_next  = hash_prod;
                state_next = S_BKT;
            end
            S_BKT:
            begin
                bucket_next = bucket_prod[32 +: BKT_W];
                state_next  = S_BCHK;
            end
            S_BCHK:
            begin
                if (bkt_rdata_reg.used)
                begin
                    node_next  = bkt_rdata_reg.first;
                    state_next = S_NCHK;
                end
                else
                begin
                    take_miss = 1'b1;
                end
            end
            S_NCHK:
            begin
                if (key_rdata_reg == key_reg)
                begin
                    res_idx_next  = node_reg;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else if (node_reg == bkt_rdata_reg.last)
                begin
                    take_miss = 1'b1;
                end
                else
                begin
                    node_next = link_rdata_reg;
                end
            end
            S_WRITE:
            begin
                key_we          = 1'b1;
                link_we         = bkt_rdata_reg.used;
                bkt_we          = 1'b1;
                bkt_waddr       = bucket_reg;
                bkt_wdata.used  = 1'b1;
                bkt_wdata.first = bkt_rdata_reg.used ? bkt_rdata_reg.first : new_idx;
                bkt_wdata.last  = new_idx;
                count_next      = count_reg + 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_index_next = idx_ext[NAME_INDEX_W-1:0];
                    out_new_next   = res_new_reg;
                    out_full_next  = res_full_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Name not found: insert it, or flag a full table
        if (take_miss)
        begin
            if (count_reg == CNT_W'(MAX_NAMES))
            begin
                res_idx_next  = '0;
                res_new_next  = 1'b0;
                res_full_next = 1'b1;
                state_next    = S_EMIT;
            end
            else
            begin
                res_idx_next  = new_idx;
                res_new_next  = 1'b1;
                res_full_next = 1'b0;
                state_next    = S_WRITE;
            end
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign name_index = out_index_reg;
    assign is_new     = out_new_reg;
    assign table_full = out_full_reg;

endmodule

`default_nettype wire

[rtl/nihm_checker.sv]
// ----------------------------------------------------------------------------
// nihm_checker
// Port-level assertions for the name-to-index hash map unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "name_to_index_hash_map_unit_macros.svh"

module nihm_checker
    import nihm_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [NAME_INDEX_W-1:0] name_index,
    input wire logic                    is_new,
    input wire logic                    table_full
);

    // Hold a stalled result
    `NIHM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(name_index) && $stable(is_new) && $stable(table_full))

    // A full-table result carries index zero and no insert
    `NIHM_ASSERT(a_full_shape, clk, rst_n, out_valid && table_full |-> !is_new && name_index == '0)

    // Work on one request at a time
    `NIHM_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready)

    // Bucket clearing keeps requests out right after reset
    `NIHM_NEVER(a_clear_after_reset, clk, rst_n, $rose(rst_n) && in_ready)

endmodule

bind name_to_index_hash_map_unit nihm_checker u_nihm_checker (.*);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: name-to-index hash map unit testbench
// Drives names over the request channel and checks every result against a
// chained, Fibonacci-hashed table kept in a scoreboard. Covers short and
// long names, the empty name, codes 27..31, letters after the end mark and
// repeated names, with random idling on both channels.
// ============================================================================

class name_map_scoreboard #(int BUCKETS = 32, int MAX_NAMES = 1024);

    typedef struct packed {
        logic [nihm_pkg::NAME_INDEX_W-1:0] slot;
        logic                              fresh;
        logic                              full;
    } name_result_t;

    bit               used        [BUCKETS];
    int unsigned      chain_head  [BUCKETS];
    int unsigned      chain_tail  [BUCKETS];
    nihm_pkg::key_t   node_key    [MAX_NAMES];
    int unsigned      node_next   [MAX_NAMES];
    bit               node_linked [MAX_NAMES];
    int unsigned      stored;
    name_result_t     expected_q[$];
    int               errors;
    int               requests;
    int               hits;
    int               inserts;
    int               rejects;

    // Pack the letters into a base-27 key; missing positions shift by 27
    function nihm_pkg::key_t name_key(logic [19:0] nm);
        int unsigned key;
        bit          ended;
        logic [4:0]  code;
        key   = 0;
        ended = 1'b0;
        for (int i = 0; i < nihm_pkg::NAME_LETTERS; i++) begin
            code = nm[19 - 5*i -: 5];
            if (code == 5'd0)
                ended = 1'b1;
            if (ended)
                key = key * 27;
            else
                key = key * 27 + code;
        end
        return nihm_pkg::key_t'(key);
    endfunction

    // Fibonacci hash: top bits of the low 32 bits of key * golden ratio
    function int unsigned bucket_of(nihm_pkg::key_t key);
        logic [63:0] prod;
        logic [63:0] h;
        prod = 64'(key) * 64'(nihm_pkg::HASH_GOLDEN);
        h    = {32'd0, prod[31:0]};
        return int'((h * 64'(BUCKETS)) >> 32);
    endfunction

    // Look up or insert the name and queue the result it must produce
    function void note_request(logic [19:0] nm);
        nihm_pkg::key_t key;
        int unsigned    b;
        int unsigned    node;
        int unsigned    slot;
        bit             found;
        name_result_t   r;
        key   = name_key(nm);
        b     = bucket_of(key);
        found = 1'b0;
        slot  = 0;
        r     = '0;
        requests++;
        if (b >= BUCKETS)
            b = BUCKETS - 1;
        // Walk the chain of this bucket
        if (used[b]) begin
            node = chain_head[b];
            for (int steps = 0; steps < MAX_NAMES && node < MAX_NAMES; steps++) begin
                if (node_key[node] == key) begin
                    found = 1'b1;
                    slot  = node;
                    break;
                end
                if (!node_linked[node])
                    break;
                node = node_next[node];
            end
        end
        if (found) begin
            hits++;
        end
        else if (stored >= MAX_NAMES) begin
            r.full = 1'b1;
            rejects++;
        end
        else begin
            // Append a new node at the chain tail
            slot              = stored;
            stored++;
            node_key[slot]    = key;
            node_next[slot]   = 0;
            node_linked[slot] = 1'b0;
            if (used[b] && chain_tail[b] < MAX_NAMES) begin
                node_next[chain_tail[b]]   = slot;
                node_linked[chain_tail[b]] = 1'b1;
            end
            else begin
                used[b]       = 1'b1;
                chain_head[b] = slot;
            end
            chain_tail[b] = slot;
            r.fresh       = 1'b1;
            inserts++;
        end
        r.slot = slot[nihm_pkg::NAME_INDEX_W-1:0];
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(logic [nihm_pkg::NAME_INDEX_W-1:0] slot,
                               logic fresh, logic full);
        name_result_t r;
        if (expected_q.size() == 0) begin
            $error("unexpected result: name_index %0d is_new %0b table_full %0b",
                   slot, fresh, full);
            errors++;
            return;
        end
        r = expected_q.pop_front();
        if (slot !== r.slot) begin
            $error("name_index: expected %0d, got %0d", r.slot, slot);
            errors++;
        end
        if (fresh !== r.fresh) begin
            $error("is_new: expected %0b, got %0b", r.fresh, fresh);
            errors++;
        end
        if (full !== r.full) begin
            $error("table_full: expected %0b, got %0b", r.full, full);
            errors++;
        end
    endfunction

endclass

module tb;

    localparam int BUCKETS     = 32;
    localparam int MAX_NAMES   = 1024;
    localparam int RANDOM_REQS = 780;

    // Directed names: {letter0, letter1, letter2, letter3}
    localparam logic [19:0] DIRECTED [20] = '{
        {5'd1,  5'd0,  5'd0,  5'd0 },   // single letter
        {5'd1,  5'd0,  5'd0,  5'd0 },   // same name again
        {5'd0,  5'd0,  5'd0,  5'd0 },   // empty name
        {5'd0,  5'd5,  5'd7,  5'd9 },   // empty name, junk after end
        {5'd0,  5'd31, 5'd31, 5'd31},   // empty name, all-ones junk
        {5'd1,  5'd0,  5'd2,  5'd0 },   // same key as the single letter
        {5'd26, 5'd26, 5'd26, 5'd26},   // largest regular name
        {5'd31, 5'd31, 5'd31, 5'd31},   // out-of-alphabet codes
        {5'd27, 5'd28, 5'd29, 5'd30},
        {5'd1,  5'd2,  5'd0,  5'd0 },
        {5'd1,  5'd2,  5'd0,  5'd31},   // junk after end mark
        {5'd1,  5'd1,  5'd1,  5'd1 },
        {5'd2,  5'd0,  5'd0,  5'd0 },
        {5'd26, 5'd0,  5'd0,  5'd0 },
        {5'd1,  5'd26, 5'd1,  5'd26},
        {5'd10, 5'd21, 5'd5,  5'd0 },
        {5'd16, 5'd8,  5'd4,  5'd2 },
        {5'd26, 5'd26, 5'd26, 5'd26},   // hit on a long name
        {5'd31, 5'd31, 5'd31, 5'd31},
        {5'd1,  5'd2,  5'd0,  5'd0 }
    };

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [nihm_pkg::LETTER_W-1:0]     letter0   = '0;
    logic [nihm_pkg::LETTER_W-1:0]     letter1   = '0;
    logic [nihm_pkg::LETTER_W-1:0]     letter2   = '0;
    logic [nihm_pkg::LETTER_W-1:0]     letter3   = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [nihm_pkg::NAME_INDEX_W-1:0] name_index;
    logic                              is_new;
    logic                              table_full;

    logic                              gaps_on   = 1'b1;
    logic [19:0]                       sent_names[$];

    name_map_scoreboard #(BUCKETS, MAX_NAMES) sb;

    name_to_index_hash_map_unit #(
        .BUCKETS   (BUCKETS),
        .MAX_NAMES (MAX_NAMES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .letter0    (letter0),
        .letter1    (letter1),
        .letter2    (letter2),
        .letter3    (letter3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .name_index (name_index),
        .is_new     (is_new),
        .table_full (table_full)
    );

    // Generate the clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_ready <= gaps_on ? ($urandom_range(0, 99) >= 18) : 1'b1;
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(name_index, is_new, table_full);
    end

    // Pick one letter code, mostly from the alphabet
    function automatic logic [4:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 5'($urandom_range(27, 31));
        return 5'($urandom_range(1, 26));
    endfunction

    // Build a random name of at least min_len letters, junk after the end
    function automatic logic [19:0] fresh_name(int min_len);
        logic [19:0] nm;
        int          len;
        int          r;
        bit          junk;
        r    = $urandom_range(0, 19);
        len  = (r == 0) ? 0 : (r < 4) ? 1 : (r < 8) ? 2 : (r < 12) ? 3 : 4;
        if (len < min_len)
            len = min_len;
        junk = ($urandom_range(0, 99) < 30);
        for (int i = 0; i < 4; i++) begin
            if (i < len)
                nm[19 - 5*i -: 5] = pick_code();
            else if (i > len && junk)
                nm[19 - 5*i -: 5] = 5'($urandom_range(0, 31));
            else
                nm[19 - 5*i -: 5] = 5'd0;
        end
        return nm;
    endfunction

    // Present one request and hold it until accepted
    task automatic send_name(input logic [19:0] nm);
        if (gaps_on && $urandom_range(0, 99) < 18) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (gaps_on && $urandom_range(0, 99) < 18);
        end
        in_valid <= 1'b1;
        letter0  <= nm[19:15];
        letter1  <= nm[14:10];
        letter2  <= nm[9:5];
        letter3  <= nm[4:0];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(nm);
        sent_names.insert(sent_names.size(), nm);
    endtask

    // Pick a name already sent or a new random one
    function automatic logic [19:0] mixed_name(int repeat_pct, int min_len);
        if (sent_names.size() != 0 && $urandom_range(0, 99) < repeat_pct)
            return sent_names[$urandom_range(0, sent_names.size() - 1)];
        return fresh_name(min_len);
    endfunction

    // Main sequence
    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed names
        foreach (DIRECTED[i])
            send_name(DIRECTED[i]);

        // Random mix of hits and misses, with one stretch free of idling
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 300)
                gaps_on <= 1'b0;
            if (n == 450)
                gaps_on <= 1'b1;
            send_name(mixed_name(40, 0));
        end

        in_valid <= 1'b0;

        // Drain the pipeline
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("tb: %0d requests: %0d found, %0d inserted, %0d refused on a full table",
                 sb.requests, sb.hits, sb.inserts, sb.rejects);
        $display("tb: %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Stop a run that hangs
    initial
    begin
        #(12.0 * 3000000);
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/nihm_pkg.sv
rtl/name_to_index_hash_map_unit.sv
rtl/nihm_checker.sv
bench/tb.sv
